[rtl/core/vdi_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex dedup indexer package
// Vertex word layout, token flags shared along the cell chain, chain sizing.
// ----------------------------------------------------------------------------
package vdi_pkg;

    // Cells in the search chain; the table is interleaved over them by the
    // low index bits.
    localparam int CELL_COUNT = 8;
    localparam int CELL_W     = 3;

    localparam int VIDX_W     = 10;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;
    localparam int S_TDATA_W  = 256;

    // First member lands in the top bits, so pos_x sits in bits 31:0.
    typedef struct packed {
        logic [31:0] norm_z;
        logic [31:0] norm_y;
        logic [31:0] norm_x;
        logic [31:0] tex_v;
        logic [31:0] tex_u;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } vtx_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } tok_flags_t;

endpackage

[rtl/core/vertex_dedup_indexer_top.sv]
// ----------------------------------------------------------------------------
// Vertex dedup indexer
// Returns the index of a vertex in the unique table, appending it if unseen and the table has room.
//
//   channel  dir  word                                   user
//   s_       in   pos_x..norm_z, 8 x 32 bit, pos_x low   new_mesh
//   m_       out  vertex_index (10 bit, zero padded)     is_new, overflow
//
// One vertex at a time. With n stored entries a word is accepted, then
// ceil(n/8) table rows enter the 8-cell chain at one row per cycle, and
// once the last row has left the chain it is decided and output.
// The table needs no clearing: entries at or above the count are never used.
// Reset clears the count and the handshake state. A held result does not
// block the next accept; only the final decide step waits for m_tready.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vdi_pkg::S_TDATA_W-1:0]   s_tdata,   // pos_x, pos_y, pos_z, tex_u,
                                                       // tex_v, norm_x, norm_y, norm_z
    input  logic                            s_tuser,   // new_mesh
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vdi_pkg::M_TDATA_W-1:0]   m_tdata,   // vertex_index, zero padding
    output logic [vdi_pkg::M_TUSER_W-1:0]   m_tuser    // is_new, overflow
);
    import vdi_pkg::*;

    localparam int ROWS  = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + CELL_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = IDX_W + 1 + CNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]        state_reg,    state_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [ROW_W-1:0]  wr_row_reg,   wr_row_next;
    logic [CELL_W-1:0] wr_cell_reg,  wr_cell_next;
    logic [ROW_W-1:0]  row_reg,      row_next;
    logic              hit_reg,      hit_next;
    logic [IDX_W-1:0]  hit_idx_reg,  hit_idx_next;
    logic              m_valid_reg,  m_valid_next;
    logic [VIDX_W-1:0] m_idx_reg,    m_idx_next;
    logic              m_new_reg,    m_new_next;
    logic              m_ovf_reg,    m_ovf_next;
    tok_flags_t        issue_flags_reg, issue_flags_next;
    logic [ROW_W-1:0]  issue_row_reg;
    vtx_t              probe_reg;

    tok_flags_t        link_flags   [CELL_COUNT+1];
    logic [ROW_W-1:0]  link_row     [CELL_COUNT+1];
    logic [IDX_W-1:0]  link_hit_idx [CELL_COUNT+1];
    logic [CELL_COUNT-1:0] cell_wr_en;

    logic              s_accept;
    logic              out_free;
    logic              table_full;
    logic              do_append;
    logic [ROW_W:0]    row_inc;
    logic              last_row;
    logic [IDX_W+VIDX_W-1:0] hit_idx_ext;
    logic [IDX_W+VIDX_W-1:0] wr_idx_ext;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_append  = (state_reg == ST_DECIDE) && out_free && !hit_reg && !table_full;

    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign last_row = CMP_W'({row_inc, {CELL_W{1'b0}}}) >= CMP_W'(count_reg);

    assign hit_idx_ext = (IDX_W+VIDX_W)'(hit_idx_reg);
    assign wr_idx_ext  = (IDX_W+VIDX_W)'({wr_row_reg, wr_cell_reg});

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        wr_row_next      = wr_row_reg;
        wr_cell_next     = wr_cell_reg;
        row_next         = row_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_idx_next       = m_idx_reg;
        m_new_next       = m_new_reg;
        m_ovf_next       = m_ovf_reg;
        issue_flags_next = '0;

        // first hit word out of the chain wins; later ones come from higher rows
        if (link_flags[CELL_COUNT].valid && link_flags[CELL_COUNT].hit && !hit_reg) begin
            hit_next     = 1'b1;
            hit_idx_next = link_hit_idx[CELL_COUNT];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    hit_next = 1'b0;
                    row_next = '0;
                    if (s_tuser) begin
                        count_next   = '0;
                        wr_row_next  = '0;
                        wr_cell_next = '0;
                        state_next   = ST_DECIDE;
                    end else if (count_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                issue_flags_next.valid = 1'b1;
                issue_flags_next.last  = last_row;
                row_next               = row_inc[ROW_W-1:0];
                if (last_row) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (link_flags[CELL_COUNT].valid && link_flags[CELL_COUNT].last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (hit_reg) begin
                        m_idx_next = hit_idx_ext[VIDX_W-1:0];
                        m_new_next = 1'b0;
                        m_ovf_next = 1'b0;
                    end else if (table_full) begin
                        m_idx_next = '0;
                        m_new_next = 1'b0;
                        m_ovf_next = 1'b1;
                    end else begin
                        m_idx_next   = wr_idx_ext[VIDX_W-1:0];
                        m_new_next   = 1'b1;
                        m_ovf_next   = 1'b0;
                        count_next   = count_reg + CNT_W'(1);
                        wr_cell_next = wr_cell_reg + CELL_W'(1);
                        if (wr_cell_reg == {CELL_W{1'b1}}) begin
                            wr_row_next = wr_row_reg + ROW_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            wr_row_reg      <= '0;
            wr_cell_reg     <= '0;
            hit_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            issue_flags_reg <= '0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            wr_row_reg      <= wr_row_next;
            wr_cell_reg     <= wr_cell_next;
            hit_reg         <= hit_next;
            m_valid_reg     <= m_valid_next;
            issue_flags_reg <= issue_flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        hit_idx_reg   <= hit_idx_next;
        m_idx_reg     <= m_idx_next;
        m_new_reg     <= m_new_next;
        m_ovf_reg     <= m_ovf_next;
        issue_row_reg <= row_reg;
        if (s_accept) begin
            probe_reg <= vtx_t'(s_tdata);
        end
    end

    assign link_flags[0]   = issue_flags_reg;
    assign link_row[0]     = issue_row_reg;
    assign link_hit_idx[0] = '0;

    genvar k;
    generate
        for (k = 0; k < CELL_COUNT; k++) begin : g_cell
            assign cell_wr_en[k] = do_append && (wr_cell_reg == CELL_W'(k));

            vdi_cell #(
                .ROWS    (ROWS),
                .ROW_W   (ROW_W),
                .IDX_W   (IDX_W),
                .CNT_W   (CNT_W),
                .CELL_ID (k)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .probe       (probe_reg),
                .count       (count_reg),
                .wr_en       (cell_wr_en[k]),
                .wr_row      (wr_row_reg),
                .wr_data     (probe_reg),
                .in_flags    (link_flags[k]),
                .in_row      (link_row[k]),
                .in_hit_idx  (link_hit_idx[k]),
                .out_flags   (link_flags[k+1]),
                .out_row     (link_row[k+1]),
                .out_hit_idx (link_hit_idx[k+1])
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_idx_reg);
    assign m_tuser  = {m_ovf_reg, m_new_reg};

endmodule

[rtl/core/vdi_cell.sv]
// ----------------------------------------------------------------------------
// Vertex dedup search cell
// Holds one bank of the unique table (every CELL_COUNT-th entry). A search
// token passes through a bank read register, then a compare and hand-on register.
// ----------------------------------------------------------------------------
module vdi_cell #(
    parameter int ROWS    = 128,
    parameter int ROW_W   = 7,
    parameter int IDX_W   = 10,
    parameter int CNT_W   = 11,
    parameter int CELL_ID = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vdi_pkg::vtx_t          probe,
    input  logic [CNT_W-1:0]       count,
    input  logic                   wr_en,
    input  logic [ROW_W-1:0]       wr_row,
    input  vdi_pkg::vtx_t          wr_data,
    input  vdi_pkg::tok_flags_t    in_flags,
    input  logic [ROW_W-1:0]       in_row,
    input  logic [IDX_W-1:0]       in_hit_idx,
    output vdi_pkg::tok_flags_t    out_flags,
    output logic [ROW_W-1:0]       out_row,
    output logic [IDX_W-1:0]       out_hit_idx
);
    import vdi_pkg::*;

    localparam int CMP_W = IDX_W + CNT_W;
    localparam logic [CELL_W-1:0] ID = CELL_W'(CELL_ID);

    vtx_t             bank [ROWS];
    vtx_t             rd_data_reg;
    tok_flags_t       st_flags_reg;
    logic [ROW_W-1:0] st_row_reg;
    logic [IDX_W-1:0] st_hit_idx_reg;
    tok_flags_t       out_flags_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [IDX_W-1:0] out_hit_idx_reg;

    logic [IDX_W-1:0] entry_idx;
    logic             in_range;
    logic             fields_match;
    logic             hit_here;

    function automatic logic fp_nan(input logic [31:0] a);
        return a[30:0] > 31'h7F80_0000;
    endfunction

    // IEEE equality: +0 == -0, NaN equals nothing
    function automatic logic fp_equal(input logic [31:0] a, input logic [31:0] b);
        logic both_zero;
        both_zero = ((a[30:0] | b[30:0]) == 31'd0);
        return !fp_nan(a) && !fp_nan(b) && (both_zero || (a == b));
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bank[wr_row] <= wr_data;
        end
        rd_data_reg <= bank[in_row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_flags_reg  <= '0;
            out_flags_reg <= '0;
        end else begin
            st_flags_reg        <= in_flags;
            out_flags_reg.valid <= st_flags_reg.valid;
            out_flags_reg.last  <= st_flags_reg.last;
            out_flags_reg.hit   <= st_flags_reg.hit | hit_here;
        end
    end

    always_ff @(posedge aclk) begin
        st_row_reg      <= in_row;
        st_hit_idx_reg  <= in_hit_idx;
        out_row_reg     <= st_row_reg;
        out_hit_idx_reg <= hit_here ? entry_idx : st_hit_idx_reg;
    end

    assign entry_idx    = {st_row_reg, ID};
    assign in_range     = CMP_W'(entry_idx) < CMP_W'(count);
    assign fields_match = fp_equal(rd_data_reg.pos_x,  probe.pos_x)  &&
                          fp_equal(rd_data_reg.pos_y,  probe.pos_y)  &&
                          fp_equal(rd_data_reg.pos_z,  probe.pos_z)  &&
                          fp_equal(rd_data_reg.tex_u,  probe.tex_u)  &&
                          fp_equal(rd_data_reg.tex_v,  probe.tex_v)  &&
                          fp_equal(rd_data_reg.norm_x, probe.norm_x) &&
                          fp_equal(rd_data_reg.norm_y, probe.norm_y) &&
                          fp_equal(rd_data_reg.norm_z, probe.norm_z);
    // only the first hit along the chain counts
    assign hit_here = st_flags_reg.valid && !st_flags_reg.hit && in_range && fields_match;

    assign out_flags   = out_flags_reg;
    assign out_row     = out_row_reg;
    assign out_hit_idx = out_hit_idx_reg;

endmodule
